// File: src/cubed_sphere_tan_point_map_assert.svh
// Assertion macros shared by the point map.
`ifndef CUBED_SPHERE_TAN_POINT_MAP_ASSERT_SVH
`define CUBED_SPHERE_TAN_POINT_MAP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define CSTP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CSTP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cstp_pkg.sv
package cstp_pkg;

    localparam int CoordWidthDef = 32;
    localparam int FracBitsDef   = 16;

    // Q1.30 constants.
    localparam int          CordicSteps = 30;
    localparam logic [31:0] OneQ30      = 32'h4000_0000;
    localparam logic [29:0] Pi4Q30      = 30'd843314857;

    // Largest magnitude normalized into [2^30, 2^31).
    localparam int NormWidth = 31;
    localparam int SumWidth  = 64;
    localparam int RootWidth = 32;
    localparam int UnitWidth = 31;
    localparam int TanWidth  = 31;
    localparam int DivSteps  = 31;
    localparam int SqrtSteps = 32;

    // CORDIC datapath width, Q1.30 with headroom.
    localparam int CordWidth = 34;

    // Shift code: s + 32 keeps the signed shift nonnegative.
    localparam int ShiftWidth = 7;

    // Angle table, atan(2^-i) in Q1.30.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h3243F6A8;
                5'd1:  v = 32'h1DAC6705;
                5'd2:  v = 32'h0FADBAFC;
                5'd3:  v = 32'h07F56EA6;
                5'd4:  v = 32'h03FEAB76;
                5'd5:  v = 32'h01FFD55B;
                5'd6:  v = 32'h00FFFAAA;
                5'd7:  v = 32'h007FFF55;
                5'd8:  v = 32'h003FFFEA;
                5'd9:  v = 32'h001FFFFD;
                5'd10: v = 32'h000FFFFF;
                5'd11: v = 32'h0007FFFF;
                5'd12: v = 32'h0003FFFF;
                5'd13: v = 32'h0001FFFF;
                5'd14: v = 32'h0000FFFF;
                5'd15: v = 32'h00007FFF;
                5'd16: v = 32'h00003FFF;
                5'd17: v = 32'h00001FFF;
                5'd18: v = 32'h00000FFF;
                5'd19: v = 32'h000007FF;
                5'd20: v = 32'h000003FF;
                5'd21: v = 32'h000001FF;
                5'd22: v = 32'h000000FF;
                5'd23: v = 32'h0000007F;
                5'd24: v = 32'h0000003F;
                5'd25: v = 32'h0000001F;
                5'd26: v = 32'h0000000F;
                5'd27: v = 32'h00000008;
                5'd28: v = 32'h00000004;
                5'd29: v = 32'h00000002;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: src/cstp_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module cstp_sqrt_pipe #(
    parameter int TagWidth = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [cstp_pkg::SumWidth-1:0]    in_sum,
    input  logic [TagWidth-1:0]              in_tag,
    output logic                             out_valid,
    output logic [cstp_pkg::RootWidth-1:0]   out_root,
    output logic [TagWidth-1:0]              out_tag
);
    localparam int N = cstp_pkg::SqrtSteps;
    localparam int RW = cstp_pkg::RootWidth;
    localparam int SW = cstp_pkg::SumWidth;

    logic [N:0]          v_reg;
    logic [SW-1:0]       rem_reg  [N+1];
    logic [SW-1:0]       num_reg  [N+1];
    logic [RW-1:0]       root_reg [N+1];
    logic [TagWidth-1:0] tag_reg  [N+1];

    assign v_reg[0]    = in_valid;
    assign rem_reg[0]  = '0;
    assign num_reg[0]  = in_sum;
    assign root_reg[0] = '0;
    assign tag_reg[0]  = in_tag;

    // Restoring square root, two radicand bits enter each stage.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [SW-1:0] trial;
        logic [SW-1:0] rem_sh;
        logic          fits;
        assign rem_sh = {rem_reg[i][SW-3:0], num_reg[i][SW-1:SW-2]};
        assign trial  = {root_reg[i][RW-1:0], 2'b01} & {SW{1'b1}};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1]  <= fits ? rem_sh - trial : rem_sh;
                num_reg[i+1]  <= {num_reg[i][SW-3:0], 2'b00};
                root_reg[i+1] <= {root_reg[i][RW-2:0], fits};
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

// File: src/cstp_div_pipe.sv
// Pipelined fraction divider: floor(num * 2^30 / den) for num <= den,
// one quotient bit per stage.
module cstp_div_pipe #(
    parameter int TagWidth = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [cstp_pkg::RootWidth:0]      in_num,
    input  logic [cstp_pkg::RootWidth:0]      in_den,
    input  logic [TagWidth-1:0]               in_tag,
    output logic                              out_valid,
    output logic [cstp_pkg::UnitWidth-1:0]    out_quot,
    output logic [TagWidth-1:0]               out_tag
);
    localparam int N  = cstp_pkg::DivSteps;
    localparam int DW = cstp_pkg::RootWidth + 2;
    localparam int QW = cstp_pkg::UnitWidth;

    logic [N:0]          v_reg;
    logic [DW-1:0]       rem_reg  [N+1];
    logic [DW-1:0]       den_reg  [N+1];
    logic [QW-1:0]       quot_reg [N+1];
    logic [TagWidth-1:0] tag_reg  [N+1];

    assign v_reg[0]    = in_valid;
    assign rem_reg[0]  = {1'b0, in_num};
    assign den_reg[0]  = {1'b0, in_den};
    assign quot_reg[0] = '0;
    assign tag_reg[0]  = in_tag;

    // Restoring division; the first stage yields the integer bit.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [DW-1:0] rem_cur;
        logic          fits;
        if (i == 0) begin : g_first
            assign rem_cur = rem_reg[i];
        end else begin : g_next
            assign rem_cur = {rem_reg[i][DW-2:0], 1'b0};
        end
        assign fits = rem_cur >= den_reg[i];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1]  <= fits ? rem_cur - den_reg[i] : rem_cur;
                den_reg[i+1]  <= den_reg[i];
                quot_reg[i+1] <= {quot_reg[i][QW-2:0], fits};
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_quot  = quot_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

// File: src/cstp_cordic_pipe.sv
// Pipelined CORDIC in rotation mode, one micro-rotation per stage.
module cstp_cordic_pipe #(
    parameter int TagWidth = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [cstp_pkg::UnitWidth-1:0]     in_theta,
    input  logic [TagWidth-1:0]                in_tag,
    output logic                               out_valid,
    output logic signed [cstp_pkg::CordWidth-1:0] out_x,
    output logic signed [cstp_pkg::CordWidth-1:0] out_y,
    output logic [TagWidth-1:0]                out_tag
);
    localparam int N  = cstp_pkg::CordicSteps;
    localparam int CW = cstp_pkg::CordWidth;

    logic [N:0]                v_reg;
    logic signed [CW-1:0]      x_reg [N+1];
    logic signed [CW-1:0]      y_reg [N+1];
    logic signed [CW-1:0]      z_reg [N+1];
    logic [TagWidth-1:0]       tag_reg [N+1];

    assign v_reg[0]   = in_valid;
    assign x_reg[0]   = CW'(cstp_pkg::OneQ30);
    assign y_reg[0]   = '0;
    assign z_reg[0]   = CW'(in_theta);
    assign tag_reg[0] = in_tag;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] ang;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign ang = CW'(cstp_pkg::atan_q30(5'(i)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        // A nonnegative residual angle rotates forward.
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ang;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = x_reg[N];
    assign out_y     = y_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

// File: src/cubed_sphere_tan_point_map.sv
// Channel  Ports                                   Direction
// input    s_valid s_ready s_point_x/y/z           in
// result   m_valid m_ready m_mapped_x/y/z m_zero_length out
//
// One point enters per cycle while the pipeline advances. An accepted point
// raises m_valid after passing stages 1 to 5, the square root, divider,
// CORDIC and tangent divider pipelines in series, and stages 8, 11 and 12.
// Reset clears every valid bit; payload registers are not reset.
// When the result register is full and not taken, the whole pipeline
// holds, so a stall loses and repeats nothing.
module cubed_sphere_tan_point_map #(
    parameter int COORD_WIDTH = cstp_pkg::CoordWidthDef,
    parameter int FRAC_BITS   = cstp_pkg::FracBitsDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_mapped_x,
    output logic signed [COORD_WIDTH-1:0] m_mapped_y,
    output logic signed [COORD_WIDTH-1:0] m_mapped_z,
    output logic                          m_zero_length
);
`include "cubed_sphere_tan_point_map_assert.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = COORD_WIDTH;       // magnitude width, holds 2^(CW-1)
    localparam int LW  = $clog2(COORD_WIDTH + 1);
    localparam int NW  = cstp_pkg::NormWidth;
    localparam int RW  = cstp_pkg::RootWidth;
    localparam int UW  = cstp_pkg::UnitWidth;
    localparam int TW  = cstp_pkg::TanWidth;
    localparam int SHW = cstp_pkg::ShiftWidth;
    localparam int SBias = 32;
    localparam int FracUnused = FRAC_BITS;   // format passes through unchanged

    // Per-item side data carried along the pipeline.
    typedef struct packed {
        logic [2:0]     neg;
        logic [2:0]     nz;
        logic           zero;
        logic [SHW-1:0] shc;
    } side_t;
    localparam int SideW = $bits(side_t);

    // Whole pipeline advances unless the result register is stuck.
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage 1: magnitudes and signs.
    logic             v1_reg;
    logic [MW-1:0]    mag1_reg [3];
    logic [2:0]       neg1_reg;
    logic signed [CW-1:0] pin [3];
    assign pin[0] = s_point_x;
    assign pin[1] = s_point_y;
    assign pin[2] = s_point_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_mag
        always_ff @(posedge aclk) begin
            if (adv) begin
                neg1_reg[k] <= pin[k][CW-1];
                mag1_reg[k] <= pin[k][CW-1] ? MW'(-pin[k]) : MW'(pin[k]);
            end
        end
    end

    // Stage 2: maximum magnitude and its bit length.
    logic          v2_reg;
    logic [MW-1:0] mag2_reg [3];
    logic [2:0]    neg2_reg;
    logic [LW-1:0] len2_reg;
    logic [MW-1:0] maxm;
    logic [LW-1:0] len_next;
    always_comb begin
        maxm = mag1_reg[0];
        if (mag1_reg[1] > maxm) maxm = mag1_reg[1];
        if (mag1_reg[2] > maxm) maxm = mag1_reg[2];
        len_next = '0;
        for (int b = 0; b < MW; b++) begin
            if (maxm[b]) len_next = LW'(b + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            len2_reg <= len_next;
        end
    end

    // Stage 3: normalize so the largest magnitude lies in [2^30, 2^31).
    logic          v3_reg;
    logic [NW-1:0] q3_reg [3];
    side_t         side3_reg;
    logic [SHW-1:0] shc_next;
    assign shc_next = SHW'(len2_reg) + SHW'(SBias - 31);

    for (genvar k = 0; k < 3; k++) begin : g_norm
        logic [MW+NW-1:0] wide;
        logic [MW+NW-1:0] shifted;
        assign wide = {{NW{1'b0}}, mag2_reg[k]} << NW;
        assign shifted = wide >> (NW + int'(len2_reg) - 31);
        always_ff @(posedge aclk) begin
            if (adv) begin
                q3_reg[k] <= NW'(shifted);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg.neg  <= neg2_reg;
            side3_reg.nz   <= {mag2_reg[2] != '0, mag2_reg[1] != '0, mag2_reg[0] != '0};
            side3_reg.zero <= len2_reg == '0;
            side3_reg.shc  <= shc_next;
        end
    end

    // Stage 4: squares.
    logic          v4_reg;
    logic [2*NW-1:0] sq4_reg [3];
    logic [NW-1:0] q4_reg [3];
    side_t         side4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end
    for (genvar k = 0; k < 3; k++) begin : g_sq
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq4_reg[k] <= q3_reg[k] * q3_reg[k];
                q4_reg[k]  <= q3_reg[k];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) side4_reg <= side3_reg;
    end

    // Stage 5: sum of squares.
    logic          v5_reg;
    logic [cstp_pkg::SumWidth-1:0] sum5_reg;
    logic [NW-1:0] q5_reg [3];
    side_t         side5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum5_reg  <= 64'(sq4_reg[0]) + 64'(sq4_reg[1]) + 64'(sq4_reg[2]);
            q5_reg    <= q4_reg;
            side5_reg <= side4_reg;
        end
    end

    // Square root, carrying the normalized components along.
    localparam int ST = 3 * NW + SideW;
    logic          v6;
    logic [RW-1:0] r6;
    logic [ST-1:0] t6;
    cstp_sqrt_pipe #(.TagWidth(ST)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v5_reg), .in_sum(sum5_reg),
        .in_tag({q5_reg[0], q5_reg[1], q5_reg[2], side5_reg}),
        .out_valid(v6), .out_root(r6), .out_tag(t6)
    );

    // Unit vector: three dividers in parallel.
    localparam int DT = RW + SideW;
    logic          v7 [3];
    logic [UW-1:0] u7 [3];
    logic [DT-1:0] t7 [3];
    logic [NW-1:0] q6 [3];
    side_t         side6;
    assign {q6[0], q6[1], q6[2], side6} = t6;

    for (genvar k = 0; k < 3; k++) begin : g_udiv
        cstp_div_pipe #(.TagWidth(DT)) u_div (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(v6), .in_num((RW+1)'(q6[k])), .in_den((RW+1)'(r6)),
            .in_tag({r6, side6}),
            .out_valid(v7[k]), .out_quot(u7[k]), .out_tag(t7[k])
        );
    end

    logic [RW-1:0] r7;
    side_t         side7;
    assign {r7, side7} = t7[0];

    // Angle: theta = floor(u * pi/4), then register.
    logic          v8_reg;
    logic [UW-1:0] th8_reg [3];
    logic [RW-1:0] r8_reg;
    side_t         side8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (adv) begin
            v8_reg <= v7[0];
        end
    end
    for (genvar k = 0; k < 3; k++) begin : g_ang
        logic [UW+30-1:0] prod;
        assign prod = u7[k] * cstp_pkg::Pi4Q30;
        always_ff @(posedge aclk) begin
            if (adv) th8_reg[k] <= UW'(prod >> 30);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r8_reg    <= r7;
            side8_reg <= side7;
        end
    end

    // Tangent via CORDIC.
    localparam int KW = cstp_pkg::CordWidth;
    localparam int CT = RW + SideW;
    logic                 v9 [3];
    logic signed [KW-1:0] x9 [3];
    logic signed [KW-1:0] y9 [3];
    logic [CT-1:0]        t9 [3];
    for (genvar k = 0; k < 3; k++) begin : g_cord
        cstp_cordic_pipe #(.TagWidth(CT)) u_cordic (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(v8_reg), .in_theta(th8_reg[k]), .in_tag({r8_reg, side8_reg}),
            .out_valid(v9[k]), .out_x(x9[k]), .out_y(y9[k]), .out_tag(t9[k])
        );
    end
    logic [RW-1:0] r9;
    side_t         side9;
    assign {r9, side9} = t9[0];

    // Ratio y/x; special cases decided before the divide.
    logic [2:0]    yzero9, xneg9;
    logic [RW:0]   ynum9 [3];
    logic [RW:0]   xden9 [3];
    for (genvar k = 0; k < 3; k++) begin : g_tsel
        assign yzero9[k] = (y9[k] <= 0);
        assign xneg9[k]  = (x9[k] <= 0) || (y9[k] >= x9[k]);
        assign ynum9[k]  = (yzero9[k] || xneg9[k]) ? (RW+1)'(0) : (RW+1)'(y9[k]);
        assign xden9[k]  = (yzero9[k] || xneg9[k]) ? (RW+1)'(1) : (RW+1)'(x9[k]);
    end

    localparam int TT = RW + SideW + 6;
    logic          v10 [3];
    logic [UW-1:0] tq10 [3];
    logic [TT-1:0] t10 [3];
    for (genvar k = 0; k < 3; k++) begin : g_tdiv
        cstp_div_pipe #(.TagWidth(TT)) u_tdiv (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(v9[0]), .in_num(ynum9[k]), .in_den(xden9[k]),
            .in_tag({r9, side9, yzero9, xneg9}),
            .out_valid(v10[k]), .out_quot(tq10[k]), .out_tag(t10[k])
        );
    end
    logic [RW-1:0] r10;
    side_t         side10;
    logic [2:0]    yz10, xn10;
    assign {r10, side10, yz10, xn10} = t10[0];

    // Stage 11: tangent select and r * t.
    logic             v11_reg;
    logic [RW+TW-1:0] m11_reg [3];
    side_t            side11_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
        end else if (adv) begin
            v11_reg <= v10[0];
        end
    end
    for (genvar k = 0; k < 3; k++) begin : g_mul
        logic [TW-1:0] tk;
        always_comb begin
            if (yz10[k]) begin
                tk = '0;
            end else if (xn10[k]) begin
                tk = TW'(cstp_pkg::OneQ30);
            end else begin
                tk = tq10[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) m11_reg[k] <= r10 * tk;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) side11_reg <= side10;
    end

    // Stage 12: round, rescale, saturate, sign.
    localparam int PW = RW + TW + 1;
    logic signed [CW-1:0] mo_reg [3];
    logic                 zl_reg;
    for (genvar k = 0; k < 3; k++) begin : g_out
        logic [6:0]    sh;
        logic [PW-1:0] rnd;
        logic [PW-1:0] mres;
        logic [PW-1:0] lim;
        logic [PW-1:0] sat;
        always_comb begin
            sh   = 7'(30 + SBias) - side11_reg.shc;
            rnd  = ({{1'b0}, m11_reg[k]} + (PW'(1) << (sh - 7'd1)));
            mres = rnd >> sh;
            lim  = (PW'(1) << (CW - 1)) - PW'(!side11_reg.neg[k]);
            sat  = (mres > lim) ? lim : mres;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!side11_reg.nz[k] || side11_reg.zero) begin
                    mo_reg[k] <= '0;
                end else begin
                    mo_reg[k] <= side11_reg.neg[k] ? -CW'(sat) : CW'(sat);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v11_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) zl_reg <= side11_reg.zero;
    end

    assign m_valid       = m_valid_reg;
    assign m_mapped_x    = mo_reg[0];
    assign m_mapped_y    = mo_reg[1];
    assign m_mapped_z    = mo_reg[2];
    assign m_zero_length = zl_reg && (FracUnused >= 0);

    // A zero-length result carries all-zero coordinates.
    `CSTP_ASSERT_IMP(a_zero_out, aclk, aresetn, m_valid && m_zero_length,
        m_mapped_x == '0 && m_mapped_y == '0 && m_mapped_z == '0, "zero point not zeroed")
    // A stalled result holds until taken.
    `CSTP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_mapped_x) && $stable(m_zero_length), "stalled result changed")
    // Input is taken exactly when the output side can move.
    `CSTP_ASSERT_IMP(a_ready, aclk, aresetn, 1'b1,
        s_ready == (!m_valid || m_ready), "ready mismatch")
endmodule
